>>> sv/pmsc_pkg.sv
// Shared types and constants of the PID motor speed controller.
// No dependencies; compiled first.
package pmsc_pkg;

  // Configuration port geometry
  localparam int DATA_W = 32;
  localparam int ADDR_W = 5;

  // Payload widths
  localparam int SETPOINT_W = 10;
  localparam int DUTY_W     = 8;
  localparam int SPEED_W    = 24;
  localparam int ERR_W      = 25;
  localparam int DIFF_W     = 26;

  // Shared multiplier and accumulator widths
  localparam int MUL_A_W = 33;
  localparam int MUL_B_W = 26;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;
  localparam int ACC_W   = 48;
  localparam int FRAC_W  = 16;

  // Speed saturates here
  localparam logic [SPEED_W-1:0] SPEED_MAX = 24'd16711425;

  // Item kinds
  localparam logic KIND_EDGE = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  // Register indexes (byte address / 4)
  localparam logic [2:0] REG_KP            = 3'd0;
  localparam logic [2:0] REG_KI_DT         = 3'd1;
  localparam logic [2:0] REG_KD_OVER_DT    = 3'd2;
  localparam logic [2:0] REG_OUT_MAX       = 3'd3;
  localparam logic [2:0] REG_OUT_MIN       = 3'd4;
  localparam logic [2:0] REG_TICK_DIVIDE   = 3'd5;
  localparam logic [2:0] REG_RPM_PER_PULSE = 3'd6;

  // Control step sequencer
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SPEED,
    ST_ERR,
    ST_PROP,
    ST_INTEG,
    ST_DERIV,
    ST_ACC,
    ST_OUT
  } state_t;

endpackage

>>> sv/pmsc_in_if.sv
// Input channel of the PID motor speed controller: encoder edges and timer ticks.
// No dependencies.
interface pmsc_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [9:0] setpoint;

  modport source (output valid, kind, setpoint, input ready);
  modport sink (input valid, kind, setpoint, output ready);
endinterface

>>> sv/pmsc_out_if.sv
// Result channel of the PID motor speed controller: duty, speed and error.
// No dependencies.
interface pmsc_out_if;
  logic               valid;
  logic               ready;
  logic [7:0]         duty;
  logic [23:0]        measured_rpm;
  logic signed [24:0] speed_error;

  modport source (output valid, duty, measured_rpm, speed_error, input ready);
  modport sink (input valid, duty, measured_rpm, speed_error, output ready);
endinterface

>>> sv/pmsc_mult.sv
// Shared signed multiplier with a registered product.
// Depends on pmsc_pkg for operand widths.
module pmsc_mult
  import pmsc_pkg::*;
(
  input  logic                      clk,
  input  logic signed [MUL_A_W-1:0] a,
  input  logic signed [MUL_B_W-1:0] b,
  output logic signed [MUL_P_W-1:0] product
);

  // Register the full product
  always_ff @(posedge clk) begin
    product <= a * b;
  end

endmodule

>>> sv/pid_motor_speed_controller_core.sv
// PID motor speed controller core. Depends on pmsc_pkg, pmsc_in_if, pmsc_out_if, pmsc_mult.
// An encoder edge or a tick that does not end a period is taken in idle and leaves the input ready.
// A tick that ends a period runs a control step through SPEED, ERR, PROP, INTEG, DERIV,
// ACC and OUT: four products pass one at a time through the shared multiplier; the result
// is registered as OUT returns to IDLE, where the next item is taken; OUT waits while the previous result is unread.
// Synchronous reset loads register defaults and clears tally, divider, error and integral.
module pid_motor_speed_controller_core
  import pmsc_pkg::*;
#(
  parameter int PULSE_COUNT_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  pmsc_in_if.sink           item_in,
  pmsc_out_if.source        result_out,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  // Configuration registers
  logic [31:0] kp;
  logic [31:0] ki_dt;
  logic [31:0] kd_over_dt;
  logic [7:0]  out_max;
  logic [7:0]  out_min;
  logic [15:0] tick_divide;
  logic [7:0]  rpm_per_pulse;

  // Controller state
  logic [PULSE_COUNT_BITS-1:0] pulse_tally;
  logic [PULSE_COUNT_BITS-1:0] tally_snap;
  logic [15:0]                 tick_divider;
  logic signed [ERR_W-1:0]     previous_error;
  logic [DUTY_W-1:0]           integral_sum;

  // Step datapath
  logic [SETPOINT_W-1:0]       setpoint;
  logic [SPEED_W-1:0]          speed;
  logic signed [ERR_W-1:0]     err;
  logic signed [DIFF_W-1:0]    diff;
  logic signed [ACC_W-1:0]     acc;
  logic signed [ACC_W-1:0]     integ_new;

  // Result register
  logic                        out_valid;
  logic [DUTY_W-1:0]           out_duty;
  logic [SPEED_W-1:0]          out_rpm;
  logic signed [ERR_W-1:0]     out_error;

  state_t state, state_next;

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] prod;
  logic signed [ACC_W-1:0]   prod_sh;
  logic [SPEED_W-1:0]        speed_sat;
  logic signed [ERR_W-1:0]   err_calc;
  logic signed [ACC_W-1:0]   y;

  logic in_fire;
  logic out_free;
  logic cfg_wr;
  logic step_start;

  // Clamp to the output limits, upper test first
  function automatic logic [DUTY_W-1:0] clamp_limits(
    input logic signed [ACC_W-1:0] v,
    input logic [DUTY_W-1:0]       hi,
    input logic [DUTY_W-1:0]       lo
  );
    logic [DUTY_W-1:0] r;
    if (v > $signed(ACC_W'(hi))) begin
      r = hi;
    end else if (v < $signed(ACC_W'(lo))) begin
      r = lo;
    end else begin
      r = v[DUTY_W-1:0];
    end
    return r;
  endfunction

  // Handshakes
  assign in_fire    = item_in.valid && item_in.ready;
  assign out_free   = !out_valid || result_out.ready;
  assign cfg_wr     = psel && penable && pwrite;
  assign step_start = in_fire && (item_in.kind == KIND_TICK) && (tick_divider >= tick_divide);

  assign item_in.ready           = (state == ST_IDLE);
  assign result_out.valid        = out_valid;
  assign result_out.duty         = out_duty;
  assign result_out.measured_rpm = out_rpm;
  assign result_out.speed_error  = out_error;
  assign pready                  = 1'b1;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      kp            <= 32'd13107;
      ki_dt         <= 32'd229;
      kd_over_dt    <= 32'd655;
      out_max       <= 8'd255;
      out_min       <= 8'd0;
      tick_divide   <= 16'd10;
      rpm_per_pulse <= 8'd3;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        REG_KP:            kp            <= pwdata;
        REG_KI_DT:         ki_dt         <= pwdata;
        REG_KD_OVER_DT:    kd_over_dt    <= pwdata;
        REG_OUT_MAX:       out_max       <= pwdata[7:0];
        REG_OUT_MIN:       out_min       <= pwdata[7:0];
        REG_TICK_DIVIDE:   tick_divide   <= pwdata[15:0];
        REG_RPM_PER_PULSE: rpm_per_pulse <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Read back configuration registers
  always_comb begin
    unique case (paddr[4:2])
      REG_KP:            prdata = kp;
      REG_KI_DT:         prdata = ki_dt;
      REG_KD_OVER_DT:    prdata = kd_over_dt;
      REG_OUT_MAX:       prdata = DATA_W'(out_max);
      REG_OUT_MIN:       prdata = DATA_W'(out_min);
      REG_TICK_DIVIDE:   prdata = DATA_W'(tick_divide);
      REG_RPM_PER_PULSE: prdata = DATA_W'(rpm_per_pulse);
      default:           prdata = '0;
    endcase
  end

  // Count edges and ticks; snapshot the tally when a step starts
  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_tally  <= '0;
      tick_divider <= '0;
    end else if (in_fire) begin
      if (item_in.kind == KIND_EDGE) begin
        if (pulse_tally != '1) begin
          pulse_tally <= pulse_tally + 1'b1;
        end
      end else if (step_start) begin
        tick_divider <= 16'd1;
        pulse_tally  <= '0;
      end else begin
        tick_divider <= tick_divider + 16'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step_start) begin
      tally_snap <= pulse_tally;
      setpoint   <= item_in.setpoint;
    end
  end

  // Sequencer state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and multiplier operand select
  always_comb begin
    state_next = state;
    mul_a      = $signed({1'b0, kp});
    mul_b      = DIFF_W'(err);
    unique case (state)
      ST_IDLE: begin
        if (step_start) begin
          state_next = ST_SPEED;
        end
      end
      ST_SPEED: begin
        mul_a      = $signed(MUL_A_W'(tally_snap));
        mul_b      = $signed(MUL_B_W'(rpm_per_pulse));
        state_next = ST_ERR;
      end
      ST_ERR: begin
        state_next = ST_PROP;
      end
      ST_PROP: begin
        mul_a      = $signed({1'b0, kp});
        mul_b      = DIFF_W'(err);
        state_next = ST_INTEG;
      end
      ST_INTEG: begin
        mul_a      = $signed({1'b0, ki_dt});
        mul_b      = DIFF_W'(err);
        state_next = ST_DERIV;
      end
      ST_DERIV: begin
        mul_a      = $signed({1'b0, kd_over_dt});
        mul_b      = diff;
        state_next = ST_ACC;
      end
      ST_ACC: begin
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  pmsc_mult u_mult (
    .clk     (clk),
    .a       (mul_a),
    .b       (mul_b),
    .product (prod)
  );

  // Product in Q16.16 floored to integer units
  assign prod_sh = ACC_W'(prod >>> FRAC_W);

  // Saturate speed and form the error
  assign speed_sat = ($unsigned(prod) > MUL_P_W'(SPEED_MAX)) ? SPEED_MAX : prod[SPEED_W-1:0];
  assign err_calc  = $signed(ERR_W'(setpoint)) - $signed(ERR_W'(speed_sat));
  assign y         = acc + integ_new;

  // Step datapath
  always_ff @(posedge clk) begin
    unique case (state)
      ST_ERR: begin
        speed <= speed_sat;
        err   <= err_calc;
        diff  <= DIFF_W'(err_calc) - DIFF_W'(previous_error);
      end
      ST_INTEG: acc <= prod_sh;
      ST_DERIV: integ_new <= $signed(ACC_W'(integral_sum)) + prod_sh;
      ST_ACC:   acc <= acc + prod_sh;
      default: ;
    endcase
  end

  // Commit the step: integral clamp, error history, result register
  always_ff @(posedge clk) begin
    if (rst) begin
      previous_error <= '0;
      integral_sum   <= '0;
    end else if (state == ST_OUT && out_free) begin
      previous_error <= err;
      integral_sum   <= clamp_limits(integ_new, out_max, out_min);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_OUT && out_free) begin
      out_valid <= 1'b1;
    end else if (result_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_OUT && out_free) begin
      out_duty  <= clamp_limits(y, out_max, out_min);
      out_rpm   <= speed;
      out_error <= err;
    end
  end

endmodule

>>> sv/pmsc_checker.sv
// Port-level checks of the PID motor speed controller core, bound to the core.
// Depends on pmsc_pkg and pid_motor_speed_controller_core.
module pmsc_checker
  import pmsc_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               in_kind,
  input logic               out_valid,
  input logic               out_ready,
  input logic [DUTY_W-1:0]  duty,
  input logic [SPEED_W-1:0] measured_rpm,
  input logic               psel,
  input logic               penable,
  input logic               pwrite,
  input logic [ADDR_W-1:0]  paddr,
  input logic [DATA_W-1:0]  pwdata,
  input logic [DATA_W-1:0]  prdata
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(duty) && $stable(measured_rpm))
    else $error("stalled result changed or dropped");

  // A new result follows a busy control step
  a_step_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without a control step");

  // An encoder edge never stalls the input
  a_edge_fast: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (in_kind == KIND_EDGE) |=> in_ready)
    else $error("encoder edge made the block busy");

  // A written gain reads back
  a_kp_readback: assert property (@(posedge clk) disable iff (rst)
    psel && penable && pwrite && (paddr[4:2] == REG_KP) |=>
      (paddr[4:2] != REG_KP) || (prdata == $past(pwdata)))
    else $error("proportional gain read back wrong");

endmodule

bind pid_motor_speed_controller_core pmsc_checker u_pmsc_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (item_in.valid),
  .in_ready     (item_in.ready),
  .in_kind      (item_in.kind),
  .out_valid    (result_out.valid),
  .out_ready    (result_out.ready),
  .duty         (result_out.duty),
  .measured_rpm (result_out.measured_rpm),
  .psel         (psel),
  .penable      (penable),
  .pwrite       (pwrite),
  .paddr        (paddr),
  .pwdata       (pwdata),
  .prdata       (prdata)
);

>>> dv/pmsc_speed_checker.sv
// Checker of the PID motor speed controller: watches both item channels and the
// register bus, predicts every control step and compares the duty, speed and error reports.
// Depends on pmsc_pkg, pmsc_in_if and pmsc_out_if.
module pmsc_speed_checker
  import pmsc_pkg::*;
#(
  parameter int PULSE_COUNT_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  pmsc_in_if                item_in,
  pmsc_out_if               result_out,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  input  logic              pready,
  output int                pending,
  output int                failures
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int REPORT_LIMIT = 10;
  localparam logic [PULSE_COUNT_BITS-1:0] PULSE_MAX = '1;

  // Register values after reset
  localparam logic [31:0] KP_RESET          = 32'd13107;
  localparam logic [31:0] KI_DT_RESET       = 32'd229;
  localparam logic [31:0] KD_OVER_DT_RESET  = 32'd655;
  localparam logic [7:0]  OUT_MAX_RESET     = 8'd255;
  localparam logic [7:0]  OUT_MIN_RESET     = 8'd0;
  localparam logic [15:0] TICK_DIVIDE_RESET = 16'd10;
  localparam logic [7:0]  RPM_RESET         = 8'd3;

  typedef struct packed {
    logic [DUTY_W-1:0]         duty;
    logic [SPEED_W-1:0]        measured_rpm;
    logic signed [ERR_W-1:0]   speed_error;
  } speed_report_t;

  // Shadow of the register file
  logic [31:0] cfg_kp;
  logic [31:0] cfg_ki_dt;
  logic [31:0] cfg_kd_over_dt;
  logic [7:0]  cfg_out_max;
  logic [7:0]  cfg_out_min;
  logic [15:0] cfg_tick_divide;
  logic [7:0]  cfg_rpm_per_pulse;

  // Controller state
  logic [PULSE_COUNT_BITS-1:0] pulse_tally;
  logic [15:0]                 tick_divider;
  longint                      last_error;
  longint                      integral_acc;

  speed_report_t report_q[$];
  int            outstanding;
  int            mismatches;

  assign pending  = outstanding;
  assign failures = mismatches;

  // Upper limit test first, so inverted limits give out_max on overshoot
  function automatic longint clamp_to_limits(input longint v);
    longint hi, lo;
    hi = cfg_out_max;
    lo = cfg_out_min;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // Advance the controller by one item; return 1 when a control step ran
  function automatic bit control_update(input logic kind, input logic [SETPOINT_W-1:0] sp,
                                        output speed_report_t rep);
    longint speed, err, prop, deriv, y, gain;
    rep = '0;
    if (kind == KIND_EDGE) begin
      if (pulse_tally != PULSE_MAX) pulse_tally++;
      return 1'b0;
    end
    if (tick_divider < cfg_tick_divide) begin
      tick_divider++;
      return 1'b0;
    end
    tick_divider = 16'd1;

    speed = pulse_tally * cfg_rpm_per_pulse;
    if (speed > SPEED_MAX) speed = SPEED_MAX;
    pulse_tally = '0;

    err = sp;
    err = err - speed;
    gain = cfg_kp;
    prop = (gain * err) >>> FRAC_W;
    gain = cfg_ki_dt;
    integral_acc += (gain * err) >>> FRAC_W;
    gain = cfg_kd_over_dt;
    deriv = (gain * (err - last_error)) >>> FRAC_W;
    // Output uses the integral before it is clamped
    y = prop + integral_acc + deriv;
    last_error = err;
    integral_acc = clamp_to_limits(integral_acc);
    y = clamp_to_limits(y);

    rep.duty         = y[DUTY_W-1:0];
    rep.measured_rpm = speed[SPEED_W-1:0];
    rep.speed_error  = err[ERR_W-1:0];
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    speed_report_t want, got;
    if (rst) begin
      cfg_kp            = KP_RESET;
      cfg_ki_dt         = KI_DT_RESET;
      cfg_kd_over_dt    = KD_OVER_DT_RESET;
      cfg_out_max       = OUT_MAX_RESET;
      cfg_out_min       = OUT_MIN_RESET;
      cfg_tick_divide   = TICK_DIVIDE_RESET;
      cfg_rpm_per_pulse = RPM_RESET;
      pulse_tally       = '0;
      tick_divider      = '0;
      last_error        = 0;
      integral_acc      = 0;
      report_q.delete();
      outstanding       = 0;
      mismatches        = 0;
    end else begin
      // Compare an accepted report against the oldest prediction
      if (result_out.valid && result_out.ready) begin
        got.duty         = result_out.duty;
        got.measured_rpm = result_out.measured_rpm;
        got.speed_error  = result_out.speed_error;
        if (report_q.size() == 0) begin
          if (mismatches < REPORT_LIMIT)
            $display("%0t: report with none predicted: duty %0d rpm %0d error %0d",
                     $realtime, got.duty, got.measured_rpm, got.speed_error);
          mismatches++;
        end else begin
          want = report_q.pop_front();
          outstanding = report_q.size();
          if (got.duty !== want.duty || got.measured_rpm !== want.measured_rpm ||
              got.speed_error !== want.speed_error) begin
            if (mismatches < REPORT_LIMIT)
              $display("%0t: duty %0d rpm %0d error %0d, predicted duty %0d rpm %0d error %0d",
                       $realtime, got.duty, got.measured_rpm, got.speed_error,
                       want.duty, want.measured_rpm, want.speed_error);
            mismatches++;
          end
        end
      end

      // Predict from each accepted item
      if (item_in.valid && item_in.ready) begin
        if (control_update(item_in.kind, item_in.setpoint, want)) begin
          report_q.push_back(want);
          outstanding = report_q.size();
        end
      end

      // Track register writes, keeping only the implemented bits
      if (psel && penable && pwrite && pready) begin
        case (paddr[ADDR_W-1:2])
          REG_KP:            cfg_kp            = pwdata[31:0];
          REG_KI_DT:         cfg_ki_dt         = pwdata[31:0];
          REG_KD_OVER_DT:    cfg_kd_over_dt    = pwdata[31:0];
          REG_OUT_MAX:       cfg_out_max       = pwdata[7:0];
          REG_OUT_MIN:       cfg_out_min       = pwdata[7:0];
          REG_TICK_DIVIDE:   cfg_tick_divide   = pwdata[15:0];
          REG_RPM_PER_PULSE: cfg_rpm_per_pulse = pwdata[7:0];
          default: ;
        endcase
      end
    end
  end

endmodule

>>> dv/testbench.sv
// Top of the PID motor speed controller bench: clock, reset, register writes,
// encoder and tick stimulus, result back-pressure and the verdict.
// Depends on pmsc_pkg, both channel interfaces, the core and pmsc_speed_checker.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import pmsc_pkg::*;

  localparam int PULSE_BITS     = 16;
  localparam int SETTLE_CYCLES  = 16;
  localparam int HOLD_CYCLES    = 400;
  localparam int CYCLE_LIMIT    = 600000;
  localparam int RANDOM_PHASES  = 8;
  localparam int PHASE_ITEMS    = 200;
  localparam int PRESSURE_PHASE = 2;
  localparam int BURST_EDGES    = 100;

  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_TOGGLE} stall_mode_t;

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  int                pending;
  int                failures;

  int burst_left;
  bit gaps_on;
  bit hold_off_req;

  pmsc_in_if  item_ch();
  pmsc_out_if result_ch();

  pid_motor_speed_controller_core #(.PULSE_COUNT_BITS(PULSE_BITS)) dut (
    .clk, .rst,
    .item_in(item_ch),
    .result_out(result_ch),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  pmsc_speed_checker #(.PULSE_COUNT_BITS(PULSE_BITS)) speed_check (
    .clk, .rst,
    .item_in(item_ch),
    .result_out(result_ch),
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .pending, .failures
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Setup and access cycle of one register write
  task automatic write_reg(input logic [2:0] idx, input logic [DATA_W-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(idx) << 2;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Offer one item, hold until taken, then gap at the end of a burst when gaps are on
  task automatic put_item(input logic kind, input logic [SETPOINT_W-1:0] sp);
    item_ch.valid    <= 1'b1;
    item_ch.kind     <= kind;
    item_ch.setpoint <= sp;
    do @(posedge clk); while (!item_ch.ready);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 24);
      if (gaps_on) begin
        item_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  endtask

  // Stop offering and wait until every predicted report has come back
  task automatic drain_results();
    item_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Receiver: changing stall patterns, plus one long hold-off on request
  initial begin
    stall_mode_t mode;
    int run, i;
    result_ch.ready <= 1'b0;
    forever begin
      mode = stall_mode_t'($urandom_range(0, 3));
      run  = $urandom_range(20, 200);
      for (i = 0; i < run && !hold_off_req; i++) begin
        @(posedge clk);
        case (mode)
          RX_OPEN:   result_ch.ready <= 1'b1;
          RX_COIN:   result_ch.ready <= 1'($urandom_range(0, 1));
          RX_SPARSE: result_ch.ready <= ($urandom_range(0, 3) == 0);
          default:   result_ch.ready <= i[0];
        endcase
      end
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        for (i = 0; i < HOLD_CYCLES; i++) begin
          @(posedge clk);
          result_ch.ready <= 1'b0;
        end
      end
    end
  end

  // Watchdog
  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("** pid_motor_speed_controller_core: FAILED **");
    $finish;
  end

  // Stimulus
  initial begin
    int n, ph, edge_pct;
    logic [DATA_W-1:0] rnd;
    logic [SETPOINT_W-1:0] sp;
    logic kind;

    rst              <= 1'b1;
    psel             <= 1'b0;
    penable          <= 1'b0;
    pwrite           <= 1'b0;
    paddr            <= '0;
    pwdata           <= '0;
    item_ch.valid    <= 1'b0;
    item_ch.kind     <= KIND_EDGE;
    item_ch.setpoint <= '0;
    burst_left   = 1;
    gaps_on      = 1'b1;
    hold_off_req = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: first step lands on tick tick_divide + 1
    for (n = 0; n < 5; n++) put_item(KIND_EDGE, 10'd1023);
    for (n = 0; n < 11; n++) put_item(KIND_TICK, n[0] ? 10'd1023 : 10'd0);
    drain_results();

    // Full-scale gains, step on every tick, top speed per pulse
    write_reg(REG_KP, '1);
    write_reg(REG_KI_DT, '1);
    write_reg(REG_KD_OVER_DT, '1);
    write_reg(REG_TICK_DIVIDE, '0);
    write_reg(REG_RPM_PER_PULSE, 32'd255);
    put_item(KIND_TICK, 10'd1023);
    for (n = 0; n < 3; n++) put_item(KIND_EDGE, 10'd0);
    put_item(KIND_TICK, 10'd0);
    put_item(KIND_TICK, 10'd1023);
    put_item(KIND_TICK, 10'd0);
    drain_results();

    // Inverted limits with zero and unity gains; upper bits of narrow registers set
    write_reg(REG_KP, 32'h0001_0000);
    write_reg(REG_KI_DT, '0);
    write_reg(REG_KD_OVER_DT, '0);
    write_reg(REG_OUT_MAX, 32'hFFFF_FF64);
    write_reg(REG_OUT_MIN, 32'h1234_56C8);
    write_reg(REG_TICK_DIVIDE, 32'hABCD_0001);
    write_reg(REG_RPM_PER_PULSE, 32'h8765_4300);
    put_item(KIND_EDGE, 10'd1023);
    put_item(KIND_TICK, 10'd1023);
    put_item(KIND_TICK, 10'd1023);
    put_item(KIND_TICK, 10'd0);
    put_item(KIND_TICK, 10'd0);
    drain_results();

    // Long back-to-back edge burst, then measure at a high speed
    write_reg(REG_KP, 32'd13107);
    write_reg(REG_OUT_MAX, 32'd255);
    write_reg(REG_OUT_MIN, 32'd0);
    write_reg(REG_TICK_DIVIDE, '0);
    write_reg(REG_RPM_PER_PULSE, 32'd255);
    gaps_on = 1'b0;
    for (n = 0; n < BURST_EDGES; n++) put_item(KIND_EDGE, 10'($urandom_range(0, 1023)));
    put_item(KIND_TICK, 10'd1023);
    put_item(KIND_TICK, 10'd1023);
    gaps_on = 1'b1;
    drain_results();

    // Longest divide: ticks only count; a smaller divide then fires at once
    write_reg(REG_TICK_DIVIDE, 32'd65535);
    for (n = 0; n < 20; n++) put_item(KIND_TICK, 10'($urandom_range(0, 1023)));
    drain_results();
    write_reg(REG_TICK_DIVIDE, 32'd2);
    for (n = 0; n < 4; n++) put_item(KIND_TICK, 10'($urandom_range(0, 1023)));
    drain_results();

    // Random settings and traffic
    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      if (ph != 0) drain_results();
      rnd = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 1 << 18);
      write_reg(REG_KP, rnd);
      rnd = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 1 << 16);
      write_reg(REG_KI_DT, rnd);
      rnd = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 1 << 18);
      write_reg(REG_KD_OVER_DT, rnd);
      rnd = $urandom;
      if ($urandom_range(0, 3) != 0) rnd[7:0] = 8'($urandom_range(128, 255));
      write_reg(REG_OUT_MAX, rnd);
      rnd = $urandom;
      if ($urandom_range(0, 3) != 0) rnd[7:0] = 8'($urandom_range(0, 127));
      write_reg(REG_OUT_MIN, rnd);
      rnd = $urandom;
      rnd[15:0] = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(5, 20))
                                              : 16'($urandom_range(0, 4));
      if (ph == PRESSURE_PHASE) rnd[15:0] = '0;
      write_reg(REG_TICK_DIVIDE, rnd);
      rnd = $urandom;
      rnd[7:0] = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                             : 8'($urandom_range(0, 8));
      write_reg(REG_RPM_PER_PULSE, rnd);

      edge_pct = $urandom_range(10, 80);
      gaps_on  = (ph != PRESSURE_PHASE) && (ph != 5);
      // Hold the receiver off while ticks keep coming so the core backs up
      if (ph == PRESSURE_PHASE) begin
        edge_pct = 20;
        hold_off_req = 1'b1;
      end

      for (n = 0; n < PHASE_ITEMS; n++) begin
        kind = ($urandom_range(0, 99) < edge_pct) ? KIND_EDGE : KIND_TICK;
        if ($urandom_range(0, 7) == 0)
          sp = $urandom_range(0, 1) ? '1 : '0;
        else
          sp = 10'($urandom_range(0, 1023));
        put_item(kind, sp);
      end
    end
    drain_results();

    if (failures == 0)
      $display("** pid_motor_speed_controller_core: PASSED **");
    else
      $display("** pid_motor_speed_controller_core: FAILED **");
    $finish;
  end

endmodule

>>> filelist.f
sv/pmsc_pkg.sv
sv/pmsc_in_if.sv
sv/pmsc_out_if.sv
sv/pmsc_mult.sv
sv/pid_motor_speed_controller_core.sv
sv/pmsc_checker.sv
dv/pmsc_speed_checker.sv
dv/testbench.sv
